// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL of the empty tile detector.
// No dependencies; each file that checks itself includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never be true outside reset
`define ETD_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: condition must never hold");

// whenever ante holds, cons holds in the same cycle
`define ETD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

`endif

// ----- sv/etd_pkg.sv -----
// Package of the empty tile detector: word types, register map, constants.
// No dependencies; used by empty_tile_detector_core.
`timescale 1ns / 1ps

package etd_pkg;

    // input word: one edge image pixel
    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } pix_t;

    // output word: one finished tile
    typedef struct packed {
        logic [9:0] tile_row;
        logic [9:0] tile_col;
        logic       empty_res;
    } tile_t;

    // APB register map (index = paddr[3:2])
    localparam int          REG_AW         = 2;
    localparam int          PADDR_W        = 4;
    localparam logic [1:0]  REG_WIDTH      = 2'd0;
    localparam logic [1:0]  REG_HEIGHT     = 2'd1;
    localparam logic [1:0]  REG_START_ROW  = 2'd2;
    localparam logic [1:0]  REG_TILE_SIZE  = 2'd3;

    localparam logic [10:0] WIDTH_RST      = 11'd640;
    localparam logic [10:0] HEIGHT_RST     = 11'd480;
    localparam logic [9:0]  START_ROW_RST  = 10'd144;
    localparam logic [8:0]  TILE_SIZE_RST  = 9'd10;

    localparam int          TILE_MAX       = 256;
    localparam int          TS_W           = 9;   // holds 1..TILE_MAX
    localparam int          TPOS_W         = 8;   // position inside a tile

    // output queue
    localparam int          OQ_DEPTH       = 4;
    localparam int          OQ_AW          = 2;
    localparam int          OQ_CW          = 3;

    function automatic logic [31:0] clamp_u(input logic [31:0] v, input logic [31:0] lo,
                                            input logic [31:0] hi);
        logic [31:0] r;
        r = v;
        if (v < lo) r = lo;
        if (v > hi) r = hi;
        return r;
    endfunction

endpackage

// ----- sv/etd_ram.sv -----
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
`timescale 1ns / 1ps

module etd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/empty_tile_detector_core.sv -----
// Top level of the empty tile detector: counters, tile test, flag RAM, output queue.
// Depends on etd_pkg, etd_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Dir  Handshake                    Word
// pixel     in   pix_valid / pix_ready        pix_word  (etd_pkg::pix_t)
// tile      out  tile_valid / tile_ready      tile_word (etd_pkg::tile_t)
// config    in   APB psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// One pixel per clock sustained while pix_ready is high. The word of the pixel
// that closes a tile passes the counter stage, tile test stage and flag RAM read
// stage, then the output queue. After reset the flag RAM is swept to zero, one
// entry a cycle over all MAX_WIDTH entries (1024 by default) with pix_ready low;
// config writes work throughout. Past the sweep, pix_ready drops only when the
// 4-entry queue plus pixels in flight is full; the pipe never waits for room.

module empty_tile_detector_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // pixel input
    input  logic                              pix_valid,
    output logic                              pix_ready,
    input  etd_pkg::pix_t                     pix_word,
    // tile results
    output logic                              tile_valid,
    input  logic                              tile_ready,
    output etd_pkg::tile_t                    tile_word,
    // APB config
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [etd_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import etd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);    // column position, tile column
    localparam int RW = $clog2(MAX_HEIGHT);   // row position, tile row

    // ---------------------------------------------------------------
    // Config registers
    // ---------------------------------------------------------------
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [9:0]  start_row_reg;
    logic [8:0]  tile_size_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            start_row_reg <= START_ROW_RST;
            tile_size_reg <= TILE_SIZE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[REG_AW+1:2])
                REG_WIDTH:     width_reg     <= pwdata[10:0];
                REG_HEIGHT:    height_reg    <= pwdata[10:0];
                REG_START_ROW: start_row_reg <= pwdata[9:0];
                REG_TILE_SIZE: tile_size_reg <= pwdata[8:0];
                default:       width_reg     <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[REG_AW+1:2])
            REG_WIDTH:     prdata = {21'd0, width_reg};
            REG_HEIGHT:    prdata = {21'd0, height_reg};
            REG_START_ROW: prdata = {22'd0, start_row_reg};
            REG_TILE_SIZE: prdata = {23'd0, tile_size_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // Effective (clamped) geometry
    logic [CW:0]     w_lim;
    logic [RW:0]     h_lim;
    logic [TS_W-1:0] ts;

    assign w_lim = (CW+1)'(clamp_u(32'(width_reg), 32'd1, 32'(MAX_WIDTH)));
    assign h_lim = (RW+1)'(clamp_u(32'(height_reg), 32'd1, 32'(MAX_HEIGHT)));
    assign ts    = TS_W'(clamp_u(32'(tile_size_reg), 32'd1, 32'(TILE_MAX)));

    // ---------------------------------------------------------------
    // Flag RAM clearing sweep after reset
    // ---------------------------------------------------------------
    logic [CW-1:0] clr_cnt_reg;
    logic          clr_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (!clr_done_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CW'(MAX_WIDTH - 1))
            begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: raster position counters
    // ---------------------------------------------------------------
    logic [CW-1:0]     cc_reg, cc_next;       // column in image
    logic [RW-1:0]     rc_reg, rc_next;       // row in image
    logic [TPOS_W-1:0] cit_reg, cit_next;     // column inside tile
    logic [TPOS_W-1:0] rit_reg, rit_next;     // row inside tile
    logic [CW-1:0]     tci_reg, tci_next;     // tile column
    logic [RW-1:0]     tri_reg, tri_next;     // tile row

    // position of the current pixel (frame start forces the origin)
    logic [CW-1:0]     cc_cur;
    logic [RW-1:0]     rc_cur;
    logic [TPOS_W-1:0] cit_cur, rit_cur;
    logic [CW-1:0]     tci_cur;
    logic [RW-1:0]     tri_cur;

    logic              pix_acc;
    logic [CW:0]       cc_inc, tci_inc;
    logic [RW:0]       rc_inc, tri_inc;
    logic [TS_W-1:0]   cit_inc, rit_inc;
    logic [TS_W-1:0]   cit_adv, rit_adv;
    logic [CW:0]       tci_adv;
    logic [RW:0]       tri_adv, rc_adv;
    logic [CW:0]       cc_adv;

    assign pix_acc = pix_valid && pix_ready;

    always_comb
    begin
        if (pix_word.frame_start)
        begin
            cc_cur  = '0;
            rc_cur  = '0;
            cit_cur = '0;
            rit_cur = '0;
            tci_cur = '0;
            tri_cur = '0;
        end
        else
        begin
            cc_cur  = cc_reg;
            rc_cur  = rc_reg;
            cit_cur = cit_reg;
            rit_cur = rit_reg;
            tci_cur = tci_reg;
            tri_cur = tri_reg;
        end
    end

    always_comb
    begin
        cc_inc  = {1'b0, cc_cur} + 1'b1;
        rc_inc  = {1'b0, rc_cur} + 1'b1;
        cit_inc = {1'b0, cit_cur} + 1'b1;
        rit_inc = {1'b0, rit_cur} + 1'b1;
        tci_inc = {1'b0, tci_cur} + 1'b1;
        tri_inc = {1'b0, tri_cur} + 1'b1;

        // step along the row
        cit_adv = cit_inc;
        tci_adv = {1'b0, tci_cur};
        if (cit_inc >= ts)
        begin
            cit_adv = '0;
            tci_adv = tci_inc;
        end
        cc_adv  = cc_inc;
        rit_adv = {1'b0, rit_cur};
        tri_adv = {1'b0, tri_cur};
        rc_adv  = {1'b0, rc_cur};

        // end of image row
        if (cc_inc >= w_lim)
        begin
            cc_adv  = '0;
            cit_adv = '0;
            tci_adv = '0;
            if (32'(rc_cur) >= 32'(start_row_reg))
            begin
                rit_adv = rit_inc;
                if (rit_inc >= ts)
                begin
                    rit_adv = '0;
                    tri_adv = tri_inc;
                end
            end
            rc_adv = rc_inc;
            // end of image: wrap as for a new frame
            if (rc_inc >= h_lim)
            begin
                cc_adv  = '0;
                rc_adv  = '0;
                cit_adv = '0;
                rit_adv = '0;
                tci_adv = '0;
                tri_adv = '0;
            end
        end
        if (rit_adv >= ts)
        begin
            rit_adv = '0;
        end

        cc_next  = CW'(cc_adv);
        rc_next  = RW'(rc_adv);
        cit_next = TPOS_W'(cit_adv);
        rit_next = TPOS_W'(rit_adv);
        tci_next = CW'(tci_adv);
        tri_next = RW'(tri_adv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg  <= '0;
            rc_reg  <= '0;
            cit_reg <= '0;
            rit_reg <= '0;
            tci_reg <= '0;
            tri_reg <= '0;
        end
        else if (pix_acc)
        begin
            cc_reg  <= cc_next;
            rc_reg  <= rc_next;
            cit_reg <= cit_next;
            rit_reg <= rit_next;
            tci_reg <= tci_next;
            tri_reg <= tri_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: snapshot of the pixel position, tile bounds test
    // ---------------------------------------------------------------
    typedef struct packed {
        logic [RW-1:0]     rc;
        logic [TPOS_W-1:0] cit;
        logic [TPOS_W-1:0] rit;
        logic [CW-1:0]     tci;
        logic [RW-1:0]     trow;
        logic              nz;
    } s1_t;

    typedef struct packed {
        logic          active;   // pixel lies in a whole tile
        logic          first;    // top-left pixel of its tile
        logic          last;     // bottom-right pixel of its tile
        logic [CW-1:0] tci;
        logic [RW-1:0] trow;
        logic          nz;
    } s2_t;

    logic s1_valid_reg;
    s1_t  s1_reg;
    logic s2_valid_reg;
    s2_t  s2_reg;
    s2_t  s2_next;

    logic [RW+TS_W:0] row_span;
    logic [CW+TS_W:0] col_span;
    logic             in_rows, in_cols;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pix_acc;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_reg.rc   <= rc_cur;
            s1_reg.cit  <= cit_cur;
            s1_reg.rit  <= rit_cur;
            s1_reg.tci  <= tci_cur;
            s1_reg.trow <= tri_cur;
            s1_reg.nz   <= (pix_word.pixel != 8'd0);
        end
        s2_reg <= s2_next;
    end

    // bottom edge of this tile row / right edge of this tile column
    assign row_span = (RW+TS_W+1)'({1'b0, s1_reg.trow} + 1'b1) * (RW+TS_W+1)'(ts);
    assign col_span = (CW+TS_W+1)'({1'b0, s1_reg.tci} + 1'b1) * (CW+TS_W+1)'(ts);

    assign in_rows = (32'(s1_reg.rc) >= 32'(start_row_reg))
                  && ((32'(start_row_reg) + 32'(row_span)) <= 32'(h_lim));
    assign in_cols = 32'(col_span) <= 32'(w_lim);

    always_comb
    begin
        s2_next.active = s1_valid_reg && in_rows && in_cols;
        s2_next.first  = (s1_reg.rit == '0) && (s1_reg.cit == '0);
        s2_next.last   = ({1'b0, s1_reg.rit} == ts - 1'b1)
                      && ({1'b0, s1_reg.cit} == ts - 1'b1);
        s2_next.tci    = s1_reg.tci;
        s2_next.trow   = s1_reg.trow;
        s2_next.nz     = s1_reg.nz;
    end

    // ---------------------------------------------------------------
    // Stage 2: per-column edge flag read-modify-write
    // ---------------------------------------------------------------
    logic          ram_we;
    logic [CW-1:0] ram_waddr;
    logic          ram_wdata;
    logic          ram_q;
    logic          s2_act;
    logic          flag_old, flag_new;

    // last flag write, for the word read in the same cycle it was written
    logic          fw_valid_reg;
    logic [CW-1:0] fw_addr_reg;
    logic          fw_data_reg;

    assign s2_act = s2_valid_reg && s2_reg.active;

    assign flag_old = (fw_valid_reg && (fw_addr_reg == s2_reg.tci)) ? fw_data_reg : ram_q;
    assign flag_new = s2_reg.first ? s2_reg.nz : (flag_old || s2_reg.nz);

    assign ram_we    = !clr_done_reg || s2_act;
    assign ram_waddr = clr_done_reg ? s2_reg.tci : clr_cnt_reg;
    assign ram_wdata = clr_done_reg ? flag_new : 1'b0;

    etd_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_flags (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (s1_reg.tci),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_valid_reg <= 1'b0;
        end
        else
        begin
            fw_valid_reg <= s2_act;
        end
    end

    always_ff @(posedge clk)
    begin
        fw_addr_reg <= s2_reg.tci;
        fw_data_reg <= flag_new;
    end

    // ---------------------------------------------------------------
    // Output queue; credits cover words still in the pipe
    // ---------------------------------------------------------------
    tile_t            oq_mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wr_reg, oq_rd_reg;
    logic [OQ_CW-1:0] oq_cnt_reg;
    logic             oq_push, oq_pop;
    logic [OQ_CW:0]   inflight;
    tile_t            oq_in;

    assign oq_push = s2_act && s2_reg.last;
    assign oq_pop  = tile_valid && tile_ready;

    assign oq_in.tile_row  = 10'(32'(s2_reg.trow));
    assign oq_in.tile_col  = 10'(32'(s2_reg.tci));
    assign oq_in.empty_res = !flag_new;

    assign inflight  = {1'b0, oq_cnt_reg} + (OQ_CW+1)'(s1_valid_reg)
                     + (OQ_CW+1)'(s2_valid_reg);
    assign pix_ready = clr_done_reg && (inflight < (OQ_CW+1)'(OQ_DEPTH));

    assign tile_valid = (oq_cnt_reg != '0);
    assign tile_word  = oq_mem_reg[oq_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
            if (oq_push && !oq_pop)
            begin
                oq_cnt_reg <= oq_cnt_reg + 1'b1;
            end
            else if (oq_pop && !oq_push)
            begin
                oq_cnt_reg <= oq_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_mem_reg[oq_wr_reg] <= oq_in;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // credit scheme must keep the queue from overflowing
    `ETD_ASSERT_NEVER(a_oq_overflow, oq_push && (oq_cnt_reg == OQ_CW'(OQ_DEPTH)))
    // no pixel may enter while the flag RAM is being swept
    `ETD_ASSERT_IMPLY(a_no_pix_in_sweep, !clr_done_reg, !pix_ready)
    // stage 2 only ever holds what stage 1 held in the previous cycle
    `ETD_ASSERT_IMPLY(a_pipe_order, s2_valid_reg, $past(s1_valid_reg))

endmodule
